// ===== src/slc_pkg.sv =====
// shared constants and types for the source line classifier
`timescale 1ns / 1ps

package slc_pkg;

   // configuration register indexes
   localparam logic [2:0] CSR_COMMENTS_ENABLED = 3'd0;
   localparam logic [2:0] CSR_LINE_MARKER      = 3'd1;
   localparam logic [2:0] CSR_LINE_MARKER_LEN  = 3'd2;
   localparam logic [2:0] CSR_OPEN_MARKER      = 3'd3;
   localparam logic [2:0] CSR_OPEN_MARKER_LEN  = 3'd4;
   localparam logic [2:0] CSR_CLOSE_MARKER     = 3'd5;
   localparam logic [2:0] CSR_CLOSE_MARKER_LEN = 3'd6;

   localparam int CSR_INDEX_W  = 3;
   localparam int CSR_DATA_W   = 32;
   localparam int MARKER_W     = 32;
   localparam int MARKER_LEN_W = 3;
   localparam int MARKER_REG_BYTES = 4;
   localparam int OUT_W        = 32;
   localparam int LINE_LEN_W   = 16;

   localparam logic [7:0] NEWLINE = 8'd10;
   localparam logic [LINE_LEN_W-1:0] LINE_LEN_MAX = '1;

   typedef logic [1:0] mode_type;
   localparam mode_type MODE_REGULAR = 2'd0;
   localparam mode_type MODE_LINE    = 2'd1;
   localparam mode_type MODE_BLOCK   = 2'd2;

endpackage

// ===== src/source_line_classifier_core.sv =====
// source line classifier: marker detection, line sorting and running counts
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+---------------------------------
//  req     | in        | req_valid / req_stall  | req_text_byte (one byte a word)
//  rsp     | out       | rsp_valid / rsp_stall  | five running counts, 32 bits each
//  csr     | in        | csr_write_enable       | csr_index, csr_write_data
//
// one word a cycle sustained while rsp_stall does not hold the result; a byte is
// held in the input register, then its result is registered in the count registers
// the count registers themselves form the result register; they move only when
// the held result is taken or none is held, so a stalled result stays put
// reset is synchronous and clears control state, configuration registers and counts
// the single-cycle path is the marker compare plus one saturating add
`timescale 1ns / 1ps

module source_line_classifier_core #(
   parameter int MARKER_BYTES = 4,
   parameter int COUNT_WIDTH  = 32
) (
   input  logic                                clock,
   input  logic                                reset,
   // byte input
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [7:0]                          req_text_byte,
   // running counts
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [slc_pkg::OUT_W-1:0]           rsp_total_lines,
   output logic [slc_pkg::OUT_W-1:0]           rsp_empty_lines,
   output logic [slc_pkg::OUT_W-1:0]           rsp_code_lines,
   output logic [slc_pkg::OUT_W-1:0]           rsp_comment_lines,
   output logic [slc_pkg::OUT_W-1:0]           rsp_length_sum,
   // configuration writes
   input  logic                                csr_write_enable,
   input  logic [slc_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [slc_pkg::CSR_DATA_W-1:0]      csr_write_data
);

   // candidate length runs up to MARKER_BYTES + 1
   localparam int LEN_W   = $clog2(MARKER_BYTES + 2);
   localparam int CAND_W  = 8 * MARKER_BYTES;
   localparam int PAD_BYTES = (MARKER_BYTES > slc_pkg::MARKER_REG_BYTES) ?
                              MARKER_BYTES : slc_pkg::MARKER_REG_BYTES;
   localparam int PAD_W   = 8 * PAD_BYTES;
   localparam int SUM_W   = ((COUNT_WIDTH > slc_pkg::LINE_LEN_W) ?
                             COUNT_WIDTH : slc_pkg::LINE_LEN_W) + 1;
   localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;
   localparam logic [LEN_W-1:0]       MB_LEN    = LEN_W'(MARKER_BYTES);

   // configuration registers
   logic                                comments_enabled_ff;
   logic [slc_pkg::MARKER_W-1:0]        line_marker_ff;
   logic [slc_pkg::MARKER_LEN_W-1:0]    line_marker_len_ff;
   logic [slc_pkg::MARKER_W-1:0]        open_marker_ff;
   logic [slc_pkg::MARKER_LEN_W-1:0]    open_marker_len_ff;
   logic [slc_pkg::MARKER_W-1:0]        close_marker_ff;
   logic [slc_pkg::MARKER_LEN_W-1:0]    close_marker_len_ff;

   // input register
   logic                                byte_valid_ff, byte_valid_in;
   logic [7:0]                          byte_ff;

   // classifier state
   slc_pkg::mode_type                   mode_ff, mode_in;
   logic                                checking_ff, checking_in;
   logic [CAND_W-1:0]                   cand_bytes_ff, cand_bytes_in;
   logic [LEN_W-1:0]                    cand_len_ff, cand_len_in;
   logic                                after_close_ff, after_close_in;
   logic [slc_pkg::LINE_LEN_W-1:0]      line_length_ff, line_length_in;

   // running counts, also the result register
   logic [COUNT_WIDTH-1:0]              total_ff, total_in;
   logic [COUNT_WIDTH-1:0]              empty_ff, empty_in;
   logic [COUNT_WIDTH-1:0]              code_ff, code_in;
   logic [COUNT_WIDTH-1:0]              comment_ff, comment_in;
   logic [COUNT_WIDTH-1:0]              sum_ff, sum_in;
   logic                                rsp_valid_ff, rsp_valid_in;

   logic                                advance;
   logic                                req_accept;

   // marker length limited to the buffer depth
   function automatic logic [LEN_W-1:0] eff_len(input logic [slc_pkg::MARKER_LEN_W-1:0] len);
      logic [LEN_W+slc_pkg::MARKER_LEN_W-1:0] wide;
      begin
         wide = (LEN_W + slc_pkg::MARKER_LEN_W)'(len);
         if (wide > (LEN_W + slc_pkg::MARKER_LEN_W)'(MARKER_BYTES)) begin
            eff_len = MB_LEN;
         end else begin
            eff_len = wide[LEN_W-1:0];
         end
      end
   endfunction

   // marker bytes past the register read as zero
   function automatic logic [PAD_W-1:0] pad_marker(input logic [slc_pkg::MARKER_W-1:0] m);
      pad_marker = PAD_W'(m);
   endfunction

   function automatic logic [7:0] first_byte(input logic [slc_pkg::MARKER_W-1:0] m,
                                             input logic [LEN_W-1:0] n);
      first_byte = (n == '0) ? 8'd0 : m[7:0];
   endfunction

   function automatic logic cand_eq(input logic [CAND_W-1:0] bytes,
                                    input logic [LEN_W-1:0] len,
                                    input logic [PAD_W-1:0] m,
                                    input logic [LEN_W-1:0] n);
      logic eq;
      begin
         eq = (len == n) && (n != '0);
         for (int i = 0; i < MARKER_BYTES; i++) begin
            if (LEN_W'(i) < n && bytes[8*i +: 8] != m[8*i +: 8]) begin
               eq = 1'b0;
            end
         end
         cand_eq = eq;
      end
   endfunction

   function automatic logic [COUNT_WIDTH-1:0] sat_add(input logic [COUNT_WIDTH-1:0] v,
                                                     input logic [SUM_W-1:0] by);
      logic [SUM_W-1:0] s;
      begin
         s = SUM_W'(v) + by;
         if (s > SUM_W'(COUNT_MAX)) begin
            sat_add = COUNT_MAX;
         end else begin
            sat_add = s[COUNT_WIDTH-1:0];
         end
      end
   endfunction

   function automatic logic [slc_pkg::OUT_W-1:0] to_out(input logic [COUNT_WIDTH-1:0] v);
      logic [COUNT_WIDTH+slc_pkg::OUT_W-1:0] w;
      begin
         w = (COUNT_WIDTH + slc_pkg::OUT_W)'(v);
         to_out = w[slc_pkg::OUT_W-1:0];
      end
   endfunction

   // handshake: the held byte moves on when no result waits or it is taken
   assign advance    = byte_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall  = byte_valid_ff && !advance;
   assign req_accept = req_valid && !req_stall;

   always_comb begin
      byte_valid_in = (byte_valid_ff && !advance) || req_accept;
      rsp_valid_in  = advance || (rsp_valid_ff && rsp_stall);
   end

   // classification of the held byte
   logic                   en;
   logic                   is_newline;
   logic [LEN_W-1:0]       line_len_eff, open_len_eff, close_len_eff, longest;
   logic                   start;
   logic                   push;
   logic [LEN_W-1:0]       push_len;
   logic [CAND_W-1:0]      bytes_pushed;
   logic [LEN_W-1:0]       len_pushed;
   logic                   hit_line, hit_open, hit_close;
   logic [slc_pkg::LINE_LEN_W-1:0] line_grown;

   always_comb begin
      en            = comments_enabled_ff;
      is_newline    = (byte_ff == slc_pkg::NEWLINE);
      line_len_eff  = eff_len(line_marker_len_ff);
      open_len_eff  = eff_len(open_marker_len_ff);
      close_len_eff = eff_len(close_marker_len_ff);

      longest = line_len_eff;
      if (open_len_eff > longest) begin
         longest = open_len_eff;
      end
      if (close_len_eff > longest) begin
         longest = close_len_eff;
      end

      // a new candidate opens on the first byte of any marker
      start = en && !checking_ff && !is_newline &&
              (byte_ff == first_byte(line_marker_ff, line_len_eff) ||
               byte_ff == first_byte(open_marker_ff, open_len_eff) ||
               byte_ff == first_byte(close_marker_ff, close_len_eff));
      push     = checking_ff || start;
      push_len = checking_ff ? cand_len_ff : '0;

      bytes_pushed = cand_bytes_ff;
      for (int i = 0; i < MARKER_BYTES; i++) begin
         if (push && push_len == LEN_W'(i)) begin
            bytes_pushed[8*i +: 8] = byte_ff;
         end
      end
      len_pushed = push_len;
      if (push && push_len <= MB_LEN) begin
         len_pushed = push_len + LEN_W'(1);
      end

      hit_line  = push && cand_eq(bytes_pushed, len_pushed,
                                  pad_marker(line_marker_ff), line_len_eff);
      hit_open  = push && cand_eq(bytes_pushed, len_pushed,
                                  pad_marker(open_marker_ff), open_len_eff);
      hit_close = push && cand_eq(bytes_pushed, len_pushed,
                                  pad_marker(close_marker_ff), close_len_eff);

      line_grown = (line_length_ff == slc_pkg::LINE_LEN_MAX) ? line_length_ff :
                   line_length_ff + slc_pkg::LINE_LEN_W'(1);

      // defaults: mode, line length and counts hold; the candidate takes the pushed byte
      mode_in        = mode_ff;
      checking_in    = push;
      cand_bytes_in  = bytes_pushed;
      cand_len_in    = len_pushed;
      after_close_in = after_close_ff;
      line_length_in = line_length_ff;
      total_in       = total_ff;
      empty_in       = empty_ff;
      code_in        = code_ff;
      comment_in     = comment_ff;
      sum_in         = sum_ff;

      if (is_newline) begin
         // newline joins an open candidate but never matches or drops it
         total_in = sat_add(total_ff, SUM_W'(1));
         if (line_length_ff == '0) begin
            empty_in = sat_add(empty_ff, SUM_W'(1));
         end
         if (en && mode_ff == slc_pkg::MODE_REGULAR) begin
            code_in = sat_add(code_ff, SUM_W'(1));
         end
         if (en && (mode_ff == slc_pkg::MODE_LINE || mode_ff == slc_pkg::MODE_BLOCK ||
                    after_close_ff)) begin
            if (mode_ff == slc_pkg::MODE_LINE) begin
               mode_in = slc_pkg::MODE_REGULAR;
            end
            comment_in = sat_add(comment_ff, SUM_W'(1));
         end
         sum_in         = sat_add(sum_ff, SUM_W'(line_length_ff));
         line_length_in = '0;
      end else if (hit_line) begin
         mode_in        = slc_pkg::MODE_LINE;
         checking_in    = 1'b0;
         cand_len_in    = '0;
         after_close_in = 1'b0;
         line_length_in = line_grown;
      end else if (hit_open) begin
         mode_in        = slc_pkg::MODE_BLOCK;
         checking_in    = 1'b0;
         cand_len_in    = '0;
         after_close_in = 1'b0;
         line_length_in = line_grown;
      end else if (hit_close) begin
         // closing byte still counts toward the line
         mode_in        = slc_pkg::MODE_REGULAR;
         checking_in    = 1'b0;
         cand_len_in    = '0;
         after_close_in = 1'b1;
         line_length_in = line_grown;
      end else begin
         // drop a candidate that outgrew every marker
         if (en && len_pushed > longest) begin
            checking_in = 1'b0;
            cand_len_in = '0;
         end
         after_close_in = 1'b0;
         line_length_in = line_grown;
      end
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         comments_enabled_ff <= 1'b0;
         line_marker_ff      <= '0;
         line_marker_len_ff  <= '0;
         open_marker_ff      <= '0;
         open_marker_len_ff  <= '0;
         close_marker_ff     <= '0;
         close_marker_len_ff <= '0;
      end else if (csr_write_enable) begin
         case (csr_index)
            slc_pkg::CSR_COMMENTS_ENABLED: begin
               comments_enabled_ff <= csr_write_data[0];
            end
            slc_pkg::CSR_LINE_MARKER: begin
               line_marker_ff <= csr_write_data;
            end
            slc_pkg::CSR_LINE_MARKER_LEN: begin
               line_marker_len_ff <= csr_write_data[slc_pkg::MARKER_LEN_W-1:0];
            end
            slc_pkg::CSR_OPEN_MARKER: begin
               open_marker_ff <= csr_write_data;
            end
            slc_pkg::CSR_OPEN_MARKER_LEN: begin
               open_marker_len_ff <= csr_write_data[slc_pkg::MARKER_LEN_W-1:0];
            end
            slc_pkg::CSR_CLOSE_MARKER: begin
               close_marker_ff <= csr_write_data;
            end
            slc_pkg::CSR_CLOSE_MARKER_LEN: begin
               close_marker_len_ff <= csr_write_data[slc_pkg::MARKER_LEN_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // input register: payload needs no reset
   always_ff @(posedge clock) begin
      if (req_accept) begin
         byte_ff <= req_text_byte;
      end
   end

   // candidate bytes are payload, only bytes below the length are compared
   always_ff @(posedge clock) begin
      if (advance) begin
         cand_bytes_ff <= cand_bytes_in;
      end
   end

   // control state and counts
   always_ff @(posedge clock) begin
      if (reset) begin
         byte_valid_ff  <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         mode_ff        <= slc_pkg::MODE_REGULAR;
         checking_ff    <= 1'b0;
         cand_len_ff    <= '0;
         after_close_ff <= 1'b0;
         line_length_ff <= '0;
         total_ff       <= '0;
         empty_ff       <= '0;
         code_ff        <= '0;
         comment_ff     <= '0;
         sum_ff         <= '0;
      end else begin
         byte_valid_ff <= byte_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         if (advance) begin
            mode_ff        <= mode_in;
            checking_ff    <= checking_in;
            cand_len_ff    <= cand_len_in;
            after_close_ff <= after_close_in;
            line_length_ff <= line_length_in;
            total_ff       <= total_in;
            empty_ff       <= empty_in;
            code_ff        <= code_in;
            comment_ff     <= comment_in;
            sum_ff         <= sum_in;
         end
      end
   end

   // counts leave in their low 32 bits
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_total_lines   = to_out(total_ff);
   assign rsp_empty_lines   = to_out(empty_ff);
   assign rsp_code_lines    = to_out(code_ff);
   assign rsp_comment_lines = to_out(comment_ff);
   assign rsp_length_sum    = to_out(sum_ff);

endmodule
